// ===== rtl/smooth_weighted_round_robin_sequence_unit_macros.svh =====
// Assertion macros shared by the sequence unit RTL.
// Both expect signals clk and rst in the scope where they are used.
`ifndef SMOOTH_WEIGHTED_ROUND_ROBIN_SEQUENCE_UNIT_MACROS_SVH
`define SMOOTH_WEIGHTED_ROUND_ROBIN_SEQUENCE_UNIT_MACROS_SVH

// same-cycle implication
`define SWRR_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swrr check failed");

// next-cycle implication
`define SWRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swrr check failed");

`endif

// ===== rtl/swrr_pkg.sv =====
// Shared constants and types for the smooth weighted round robin sequence unit.
// No dependencies.
package swrr_pkg;

  localparam logic CMD_BUILD  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WCOUNT  = 3'd3;

  localparam int CFG_W     = 64;
  localparam int CFG_CNT_W = 4;
  localparam int IDS_W     = 40;
  localparam int ID_W      = 5;
  localparam int WEIGHT_W  = 8;
  localparam int LAYER_W   = 18;
  localparam int LEN_W     = 7;
  // eight weights of 255 at most
  localparam int SUM_W     = 11;
  // divisor holds twice a weight total
  localparam int DVS_W     = SUM_W + 1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/swrr_div.sv =====
// Restoring divider, one quotient bit per cycle, for the sequence unit.
// Depends on swrr_pkg.
module swrr_div #(
  parameter int DVD_W = 18
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DVD_W-1:0]           dividend,
  input  logic [swrr_pkg::DVS_W-1:0] divisor,
  output swrr_pkg::div_stat_t        stat,
  output logic [DVD_W-1:0]           quotient,
  output logic [swrr_pkg::DVS_W-1:0] remainder
);

  localparam int CW = $clog2(DVD_W + 1);

  logic                       busy;
  logic                       done;
  logic [CW-1:0]              cnt;
  logic [DVD_W-1:0]           quot;
  logic [swrr_pkg::DVS_W-1:0] rem;
  logic [swrr_pkg::DVS_W-1:0] dvs;
  logic [swrr_pkg::DVS_W:0]   shifted;
  logic [swrr_pkg::DVS_W:0]   diff;

  assign shifted = {rem, quot[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (!diff[swrr_pkg::DVS_W]) begin
        rem  <= diff[swrr_pkg::DVS_W-1:0];
        quot <= {quot[DVD_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[swrr_pkg::DVS_W-1:0];
        quot <= {quot[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quot;
  assign remainder = rem;

endmodule

// ===== rtl/smooth_weighted_round_robin_sequence_unit.sv =====
// Smooth weighted round robin sequence unit: build and lookup sequencer.
// Depends on swrr_pkg, swrr_div and smooth_weighted_round_robin_sequence_unit_macros.svh.
//
// One item at a time: start is taken while busy is low, and done marks the result for
// exactly one cycle; the receiver cannot stall, so capture it then. A lookup forms
// the layer remainder with the bit-serial divider, then reads the sequence entry; a
// lookup on an empty sequence raises done in the cycle after start. A build loads the
// weights, rescales them when their total exceeds MAX_CYCLE (one division per nonzero
// weight), then forms each sequence entry by scanning the n components, n being the
// component count; one shared adder and comparator walks the debts.
// Configure only while idle; cfg_ready is low while busy or while start is raised. A
// lookup before any build reports an empty sequence.
module smooth_weighted_round_robin_sequence_unit #(
  parameter int MAX_CYCLE      = 64,
  parameter int MAX_COMPONENTS = 8,
  parameter int SEQ_DEPTH      = 128
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 command,
  input  logic signed [swrr_pkg::LAYER_W-1:0]  layer_num,
  output logic                                 done,
  output logic [swrr_pkg::ID_W-1:0]            component_id,
  output logic [swrr_pkg::LEN_W-1:0]           sequence_length,
  output logic                                 sequence_empty,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [swrr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [swrr_pkg::CFG_W-1:0]           cfg_data
);

  `include "smooth_weighted_round_robin_sequence_unit_macros.svh"

  localparam int CW      = $clog2(MAX_COMPONENTS);
  localparam int CNT_W   = $clog2(MAX_COMPONENTS + 1);
  localparam int SEQ_W   = $clog2(SEQ_DEPTH + 1);
  localparam int AW      = $clog2(SEQ_DEPTH);
  localparam int NUM_MAX = 2 * 255 * MAX_CYCLE + 2040;
  localparam int NUM_W   = $clog2(NUM_MAX + 1);
  localparam int DVD_W   = (NUM_W > swrr_pkg::LAYER_W) ? NUM_W : swrr_pkg::LAYER_W;
  localparam int DEBT_W  = swrr_pkg::SUM_W + SEQ_W + 2;
  localparam int SUM_W   = swrr_pkg::SUM_W;
  localparam int DVS_W   = swrr_pkg::DVS_W;
  localparam int WEIGHT_W = swrr_pkg::WEIGHT_W;
  localparam int ID_W    = swrr_pkg::ID_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_FIX    = 4'd2;
  localparam logic [3:0] S_SCALE  = 4'd3;
  localparam logic [3:0] S_SWAIT  = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_UPDATE = 4'd6;
  localparam logic [3:0] S_LDIV   = 4'd7;
  localparam logic [3:0] S_LOUT   = 4'd8;

  logic [3:0]                       state;
  logic [swrr_pkg::CFG_CNT_W-1:0]   cfg_count;
  logic [swrr_pkg::IDS_W-1:0]       cfg_ids;
  logic [swrr_pkg::CFG_W-1:0]       cfg_weights;
  logic [swrr_pkg::CFG_CNT_W-1:0]   cfg_wcount;

  logic [SEQ_W-1:0]                 seq_total;
  logic [CNT_W-1:0]                 ncomp;
  logic [CNT_W-1:0]                 idx;
  logic [SUM_W-1:0]                 wsum;
  logic [SUM_W-1:0]                 nsum;
  logic                             any_w;
  logic [SEQ_W-1:0]                 step;
  logic [CW-1:0]                    best;
  logic signed [DEBT_W-1:0]         top_debt;
  logic                             lk_neg;
  logic [WEIGHT_W-1:0]              weight [MAX_COMPONENTS];
  logic signed [DEBT_W-1:0]         debt   [MAX_COMPONENTS];

  logic [ID_W-1:0]                  seq_mem [SEQ_DEPTH];
  logic [ID_W-1:0]                  rd_data;
  logic [AW-1:0]                    rd_addr;
  logic                             mem_we;
  logic [ID_W-1:0]                  mem_wdata;

  logic [CW-1:0]                    ci;
  logic [CNT_W-1:0]                 n_calc;
  logic [WEIGHT_W-1:0]              w_load;
  logic [WEIGHT_W-1:0]              w_cur;
  logic [WEIGHT_W-1:0]              w_scaled;
  logic [SUM_W-1:0]                 sum_eff;
  logic signed [DEBT_W-1:0]         debt_sum;
  logic signed [DEBT_W-1:0]         total_s;
  logic [SEQ_W-1:0]                 step_inc;
  logic [swrr_pkg::LAYER_W-1:0]     layer_raw;
  logic [swrr_pkg::LAYER_W-1:0]     layer_mag;
  logic [DVD_W-1:0]                 scale_num;
  logic [DVS_W-1:0]                 lk_pos;

  logic                             div_start;
  logic [DVD_W-1:0]                 div_dividend;
  logic [DVS_W-1:0]                 div_divisor;
  swrr_pkg::div_stat_t              div_stat;
  logic [DVD_W-1:0]                 div_quot;
  logic [DVS_W-1:0]                 div_rem;

  function automatic logic [SEQ_W-1:0] clamp_total(input logic [SUM_W-1:0] v);
    if (v > SUM_W'(SEQ_DEPTH)) begin
      return SEQ_W'(SEQ_DEPTH);
    end
    return SEQ_W'(v);
  endfunction

  assign ci       = idx[CW-1:0];
  assign n_calc   = (cfg_count > swrr_pkg::CFG_CNT_W'(MAX_COMPONENTS)) ?
                    CNT_W'(MAX_COMPONENTS) : CNT_W'(cfg_count);
  assign w_load   = (swrr_pkg::CFG_CNT_W'(idx) < cfg_wcount) ?
                    cfg_weights[ci*WEIGHT_W +: WEIGHT_W] : WEIGHT_W'(1);
  assign w_cur    = weight[ci];
  assign w_scaled = (div_quot == '0) ? WEIGHT_W'(1) : div_quot[WEIGHT_W-1:0];
  assign sum_eff  = any_w ? wsum : SUM_W'(ncomp);
  assign debt_sum = debt[ci] + $signed(DEBT_W'(w_cur));
  assign total_s  = $signed(DEBT_W'(seq_total));
  assign step_inc = step + 1'b1;

  // magnitude of the layer; the most negative value maps to itself as unsigned
  assign layer_raw = layer_num;
  assign layer_mag = layer_raw[swrr_pkg::LAYER_W-1] ? (~layer_raw + 1'b1) : layer_raw;
  assign scale_num = DVD_W'(w_cur) * DVD_W'(2 * MAX_CYCLE) + DVD_W'(wsum);

  assign div_start = (state == S_IDLE && start && command == swrr_pkg::CMD_LOOKUP &&
                      seq_total != '0) ||
                     (state == S_SCALE && idx != ncomp && w_cur != '0);
  assign div_dividend = (state == S_IDLE) ? DVD_W'(layer_mag) : scale_num;
  assign div_divisor  = (state == S_IDLE) ? DVS_W'(seq_total) : {wsum, 1'b0};

  // truncated remainder, folded to the nonnegative one
  assign lk_pos  = (lk_neg && div_rem != '0) ? DVS_W'(seq_total) - div_rem : div_rem;
  assign rd_addr = lk_pos[AW-1:0];

  assign mem_we    = (state == S_UPDATE);
  assign mem_wdata = cfg_ids[best*ID_W +: ID_W];

  swrr_div #(
    .DVD_W(DVD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seq_mem[step[AW-1:0]] <= mem_wdata;
    end
    rd_data <= seq_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      seq_total    <= '0;
      component_id <= '0;
      cfg_count    <= '0;
      cfg_ids      <= '0;
      cfg_weights  <= '0;
      cfg_wcount   <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          swrr_pkg::REG_COUNT:   cfg_count   <= cfg_data[swrr_pkg::CFG_CNT_W-1:0];
          swrr_pkg::REG_IDS:     cfg_ids     <= cfg_data[swrr_pkg::IDS_W-1:0];
          swrr_pkg::REG_WEIGHTS: cfg_weights <= cfg_data;
          swrr_pkg::REG_WCOUNT:  cfg_wcount  <= cfg_data[swrr_pkg::CFG_CNT_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            if (command == swrr_pkg::CMD_BUILD) begin
              for (int i = 0; i < MAX_COMPONENTS; i++) begin
                weight[i] <= '0;
                debt[i]   <= '0;
              end
              ncomp <= n_calc;
              idx   <= '0;
              wsum  <= '0;
              any_w <= 1'b0;
              if (n_calc == '0) begin
                seq_total    <= '0;
                component_id <= '0;
                done         <= 1'b1;
              end else begin
                state <= S_LOAD;
              end
            end else if (seq_total == '0) begin
              component_id <= '0;
              done         <= 1'b1;
            end else begin
              lk_neg <= layer_raw[swrr_pkg::LAYER_W-1];
              state  <= S_LDIV;
            end
          end
        end
        S_LOAD: begin
          weight[ci] <= w_load;
          wsum       <= wsum + SUM_W'(w_load);
          if (w_load != '0) begin
            any_w <= 1'b1;
          end
          if (idx == ncomp - 1'b1) begin
            state <= S_FIX;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_FIX: begin
          // all weights zero: every component weighs one
          if (!any_w) begin
            for (int i = 0; i < MAX_COMPONENTS; i++) begin
              weight[i] <= (i < ncomp) ? WEIGHT_W'(1) : '0;
            end
          end
          wsum <= sum_eff;
          nsum <= '0;
          idx  <= '0;
          step <= '0;
          if (sum_eff > SUM_W'(MAX_CYCLE)) begin
            state <= S_SCALE;
          end else begin
            seq_total <= clamp_total(sum_eff);
            state     <= S_SCAN;
          end
        end
        S_SCALE: begin
          if (idx == ncomp) begin
            seq_total <= clamp_total(nsum);
            idx       <= '0;
            state     <= S_SCAN;
          end else if (w_cur == '0) begin
            idx <= idx + 1'b1;
          end else begin
            state <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          if (div_stat.done) begin
            weight[ci] <= w_scaled;
            nsum       <= nsum + SUM_W'(w_scaled);
            idx        <= idx + 1'b1;
            state      <= S_SCALE;
          end
        end
        S_SCAN: begin
          debt[ci] <= debt_sum;
          // strict compare keeps the lower index on ties
          if (idx == '0 || debt_sum > top_debt) begin
            top_debt <= debt_sum;
            best     <= ci;
          end
          if (idx == ncomp - 1'b1) begin
            state <= S_UPDATE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_UPDATE: begin
          debt[best] <= top_debt - total_s;
          step       <= step_inc;
          idx        <= '0;
          if (step_inc == seq_total) begin
            component_id <= '0;
            done         <= 1'b1;
            state        <= S_IDLE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_LDIV: begin
          if (div_stat.done) begin
            state <= S_LOUT;
          end
        end
        S_LOUT: begin
          component_id <= rd_data;
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state != S_IDLE);
  // no register write while an item is taken or in flight
  assign cfg_ready       = (state == S_IDLE) && !start;
  assign sequence_length = seq_total[swrr_pkg::LEN_W-1:0];
  assign sequence_empty  = (seq_total == '0);

  `SWRR_ASSERT_IMPLY(a_div_owner, div_stat.busy || div_stat.done, state == S_SWAIT || state == S_LDIV)
  `SWRR_ASSERT_IMPLY(a_done_idle, done, !busy)
  `SWRR_ASSERT_IMPLY(a_total_bound, 1'b1, seq_total <= SEQ_W'(SEQ_DEPTH))
  `SWRR_ASSERT_IMPLY(a_lookup_addr, state == S_LDIV && div_stat.done, lk_pos < DVS_W'(seq_total))
  `SWRR_ASSERT_NEXT(a_accept_acts, start && !busy, busy || done)

endmodule
